// ----- hdl/cau_pkg.sv -----
// Shared types and command codes for the complex arithmetic unit.
package cau_pkg;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_EQ  = 4'd4,
        CMD_NE  = 4'd5,
        CMD_GT  = 4'd6,
        CMD_LT  = 4'd7,
        CMD_LE  = 4'd8,
        CMD_GE  = 4'd9
    } t_cmd;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } t_in;

    typedef struct packed {
        logic signed [15:0] res_re;
        logic signed [15:0] res_im;
        logic               flag;
        logic [1:0]         status;
    } t_out;

endpackage

// ----- hdl/cau_if.sv -----
// Valid/ready channel interface carrying one word.
interface cau_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/cau_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module cau_div #(
    parameter int NW = 44,
    parameter int DW = 33,
    parameter int TW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [TW-1:0] i_tag,
    output logic [NW-1:0] o_quo,
    output logic [TW-1:0] o_tag
);
    logic [NW-1:0] r_rem [NW+1];
    logic [NW-1:0] r_num [NW+1];
    logic [NW-1:0] r_quo [NW+1];
    logic [DW-1:0] r_den [NW+1];
    logic [TW-1:0] r_tag [NW+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_num[0] <= i_num;
            r_quo[0] <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_st
        logic [NW:0] n_tr;
        logic [NW:0] n_df;
        always_comb begin
            n_tr = {r_rem[s], r_num[s][NW-1-s]};
            n_df = n_tr - {{(NW+1-DW){1'b0}}, r_den[s]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_df[NW] ? n_tr[NW-1:0] : n_df[NW-1:0];
                r_quo[s+1] <= {r_quo[s][NW-2:0], ~n_df[NW]};
                r_num[s+1] <= r_num[s];
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
            end
        end
    end

    assign o_quo = r_quo[NW];
    assign o_tag = r_tag[NW];
endmodule

// ----- hdl/cau_core.sv -----
// Datapath: products, magnitudes, compares, divide, rounding and saturation.
module cau_core #(
    parameter int FRAC_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  cau_pkg::t_in  i_word,
    output logic          o_valid,
    output cau_pkg::t_out o_word
);
    localparam int NW = 34 + FRAC_BITS;
    localparam int DW = 33;
    localparam int TW = 4 + 32 + 1 + 1 + 1 + 2;
    localparam int LAT = NW + 4;

    // stage 1: products, plus add/sub results and operand equality
    logic [3:0] r1_cmd;
    logic signed [16:0] r1_sre, r1_sim;
    logic signed [31:0] r1_p [8];
    logic r1_eq;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cmd <= i_word.cmd;
            r1_sre <= (i_word.cmd == cau_pkg::CMD_SUB)
                ? 17'(i_word.a_re) - 17'(i_word.b_re) : 17'(i_word.a_re) + 17'(i_word.b_re);
            r1_sim <= (i_word.cmd == cau_pkg::CMD_SUB)
                ? 17'(i_word.a_im) - 17'(i_word.b_im) : 17'(i_word.a_im) + 17'(i_word.b_im);
            r1_p[0] <= i_word.a_re * i_word.b_re;
            r1_p[1] <= i_word.a_im * i_word.b_im;
            r1_p[2] <= i_word.a_re * i_word.b_im;
            r1_p[3] <= i_word.a_im * i_word.b_re;
            r1_p[4] <= i_word.a_re * i_word.a_re;
            r1_p[5] <= i_word.a_im * i_word.a_im;
            r1_p[6] <= i_word.b_re * i_word.b_re;
            r1_p[7] <= i_word.b_im * i_word.b_im;
            r1_eq <= (i_word.a_re == i_word.b_re) && (i_word.a_im == i_word.b_im);
        end
    end

    // stage 2: sums
    logic [3:0] r2_cmd;
    logic signed [32:0] r2_x, r2_y;
    logic [32:0] r2_ma, r2_mb;
    logic r2_eq;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_cmd <= r1_cmd;
            r2_eq  <= r1_eq;
            r2_ma  <= 33'(unsigned'(r1_p[4])) + 33'(unsigned'(r1_p[5]));
            r2_mb  <= 33'(unsigned'(r1_p[6])) + 33'(unsigned'(r1_p[7]));
            unique case (r1_cmd)
                cau_pkg::CMD_MUL: begin
                    r2_x <= 33'(r1_p[0]) - 33'(r1_p[1]);
                    r2_y <= 33'(r1_p[2]) + 33'(r1_p[3]);
                end
                cau_pkg::CMD_DIV: begin
                    r2_x <= 33'(r1_p[0]) + 33'(r1_p[1]);
                    r2_y <= 33'(r1_p[3]) - 33'(r1_p[2]);
                end
                default: begin
                    r2_x <= 33'(r1_sre);
                    r2_y <= 33'(r1_sim);
                end
            endcase
        end
    end

    // stage 3: flags and divide operands (2*mag*2^F + d, halved by extra quotient bit)
    logic [3:0] r3_cmd;
    logic r3_flag, r3_z, r3_sx, r3_sy;
    logic [32:0] r3_ax, r3_ay, r3_mb;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_cmd <= r2_cmd;
            r3_mb  <= r2_mb;
            r3_z   <= (r2_mb == '0);
            r3_sx  <= r2_x[32];
            r3_sy  <= r2_y[32];
            r3_ax  <= r2_x[32] ? 33'(-r2_x) : 33'(r2_x);
            r3_ay  <= r2_y[32] ? 33'(-r2_y) : 33'(r2_y);
            unique case (r2_cmd)
                cau_pkg::CMD_EQ: r3_flag <= r2_eq;
                cau_pkg::CMD_NE: r3_flag <= !r2_eq;
                cau_pkg::CMD_GT: r3_flag <= r2_ma > r2_mb;
                cau_pkg::CMD_LT: r3_flag <= r2_ma < r2_mb;
                cau_pkg::CMD_LE: r3_flag <= r2_ma <= r2_mb;
                cau_pkg::CMD_GE: r3_flag <= r2_ma >= r2_mb;
                default:         r3_flag <= 1'b0;
            endcase
        end
    end

    logic [NW-1:0] n_nx, n_ny, n_dq_x, n_dq_y;
    logic [DW-1:0] n_den;
    logic [TW-1:0] n_tag, n_tag_x, n_tag_y;
    assign n_nx  = (NW'(r3_ax) << (FRAC_BITS + 1)) + NW'(r3_mb);
    assign n_ny  = (NW'(r3_ay) << (FRAC_BITS + 1)) + NW'(r3_mb);
    assign n_den = r3_z ? DW'(1) : r3_mb;
    assign n_tag = {r3_cmd, r3_ax[15:0], r3_ay[15:0], r3_flag, r3_z, 1'b0, r3_sx, r3_sy};

    cau_div #(.NW(NW), .DW(DW), .TW(TW)) u_div_x (
        .i_clk(i_clk), .i_en(i_en), .i_num(n_nx), .i_den(n_den),
        .i_tag(n_tag), .o_quo(n_dq_x), .o_tag(n_tag_x)
    );
    cau_div #(.NW(NW), .DW(DW), .TW(TW)) u_div_y (
        .i_clk(i_clk), .i_en(i_en), .i_num(n_ny), .i_den(n_den),
        .i_tag(n_tag), .o_quo(n_dq_y), .o_tag(n_tag_y)
    );

    // arithmetic values that bypass the divider travel in parallel delay line
    logic [33:0] r_dl_x [NW+1];
    logic [33:0] r_dl_y [NW+1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dl_x[0] <= {r3_sx, r3_ax};
            r_dl_y[0] <= {r3_sy, r3_ay};
            for (int k = 0; k < NW; k++) begin
                r_dl_x[k+1] <= r_dl_x[k];
                r_dl_y[k+1] <= r_dl_y[k];
            end
        end
    end

    function automatic logic [34:0] f_mag(input logic [3:0] cmd, input logic [32:0] a,
                                          input logic [NW-1:0] q);
        logic [34:0] m;
        logic [32:0] h;
        h = 33'((33'(1) << FRAC_BITS) >> 1);
        unique case (cmd)
            cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: m = 35'(a);
            cau_pkg::CMD_MUL: m = 35'((a + h) >> FRAC_BITS);
            cau_pkg::CMD_DIV: m = (q >> 1) > NW'(35'h3_FFFF_FFFF) ? 35'h3_FFFF_FFFF
                                                                  : 35'(q >> 1);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [16:0] f_sat(input logic s, input logic [34:0] m);
        logic [16:0] r;
        if (s) r = (m > 35'd32768) ? {1'b1, 16'h8000} : {1'b0, 16'(-m[15:0])};
        else   r = (m > 35'd32767) ? {1'b1, 16'h7FFF} : {1'b0, m[15:0]};
        return r;
    endfunction

    // final stage: round, saturate
    logic [3:0] n_cmd;
    logic [16:0] n_rx, n_ry;
    assign n_cmd = n_tag_x[TW-1 -: 4];
    assign n_rx = f_sat(r_dl_x[NW][33], f_mag(n_cmd, r_dl_x[NW][32:0], n_dq_x));
    assign n_ry = f_sat(r_dl_y[NW][33], f_mag(n_cmd, r_dl_y[NW][32:0], n_dq_y));

    logic r_v [LAT+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < LAT; k++) r_v[k+1] <= r_v[k];
        end
    end

    logic n_z, n_div, n_arith;
    assign n_z = n_tag_x[3];
    assign n_div = (n_cmd == cau_pkg::CMD_DIV);
    assign n_arith = (n_cmd == cau_pkg::CMD_ADD) || (n_cmd == cau_pkg::CMD_SUB) ||
                     (n_cmd == cau_pkg::CMD_MUL) || n_div;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_div && n_z) begin
                o_word <= '{res_re: '0, res_im: '0, flag: 1'b0, status: cau_pkg::ST_DIV0};
            end else if (n_arith) begin
                o_word.res_re <= n_rx[15:0];
                o_word.res_im <= n_ry[15:0];
                o_word.flag   <= 1'b0;
                o_word.status <= (n_rx[16] || n_ry[16]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end else begin
                o_word <= '{res_re: '0, res_im: '0, flag: n_tag_x[4],
                            status: cau_pkg::ST_OK};
            end
        end
    end
    assign o_valid = r_v[LAT];
    logic n_unused;
    assign n_unused = ^{n_tag_y, n_tag_x[TW-5:5], n_tag_x[2:0]};
endmodule

// ----- hdl/complex_arithmetic_unit_top.sv -----
// Top level of the complex arithmetic unit.
// Takes one word per cycle, and the whole pipeline stalls in place while the
// output word is not taken; results pass through the bit-per-stage divider
// pipeline of NW = 34 + FRAC_BITS stages.
module complex_arithmetic_unit_top #(
    parameter int FRAC_BITS = 8
) (
    input logic i_clk,
    input logic i_rst_n,
    cau_if.sink   i_in,
    cau_if.source o_out
);
    logic n_en;
    logic n_v;
    cau_pkg::t_out n_w;
    assign n_en = o_out.ready || !o_out.valid;
    assign i_in.ready = n_en;

    cau_core #(.FRAC_BITS(FRAC_BITS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(n_en), .i_valid(i_in.valid),
        .i_word(i_in.data), .o_valid(n_v), .o_word(n_w)
    );
    assign o_out.valid = n_v;
    assign o_out.data = n_w;
endmodule

// ----- hdl/cau_checker.sv -----
// Port-level checker for the complex arithmetic unit.
module cau_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic o_out_valid,
    input logic o_out_ready,
    input cau_pkg::t_out o_out_data
);
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled word changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (o_out_ready || !o_out_valid))
        else $error("input ready mismatch");
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.flag |-> o_out_data.status == cau_pkg::ST_OK &&
        o_out_data.res_re == '0 && o_out_data.res_im == '0)
        else $error("compare word not clean");
    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == cau_pkg::ST_DIV0 |->
        o_out_data.res_re == '0 && o_out_data.res_im == '0)
        else $error("divide by zero word not zero");
endmodule

bind complex_arithmetic_unit_top cau_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .o_out_valid(o_out.valid), .o_out_ready(o_out.ready), .o_out_data(o_out.data)
);
